// ----- design/text_console_writer_defines.svh -----
// Assertion helpers shared by the console modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Internal widths derived from the geometry.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = $clog2(CELLS + 1);
    localparam int NL_W   = (ROW_W > 5) ? ROW_W : 5;

    // Field widths of the stream beats.
    localparam int FUNC_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int IN_COL_W  = 7;
    localparam int IN_ROW_W  = 5;
    localparam int LINES_W   = 5;
    localparam int POS_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Register port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_COLOR_ATTR = 1'b0;
    localparam logic [ATTR_W-1:0] COLOR_ATTR_RESET = 8'h0F;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

    // Low bits cleared to align a tab stop to a multiple of four.
    localparam int TAB_STEP = 4;
    localparam int TAB_MASK = 32'h03;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 3'd0,
        FN_SET    = 3'd1,
        FN_READ   = 3'd2,
        FN_CLEAR  = 3'd3,
        FN_SCROLL = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_ONE,
        SW_ITEM
    } sweep_kind_t;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_EXEC,
        ST_WRAP,
        ST_READ,
        ST_SWEEP,
        ST_SWEEP_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load_item;
        logic        exec;
        logic        sweep_start;
        sweep_kind_t sweep_kind;
        logic        sweep_copy_rd;
        logic        sweep_copy_wr;
        logic        sweep_zero;
        logic        capture_cell;
        logic        load_out;
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              lines_zero;
        logic              wrap;
        logic              sweep_copy;
        logic              sweep_last;
    } tcw_sts_t;

endpackage

// ----- design/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tcw_datapath.sv -----
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::tcw_cmd_t           cmd,
    output tcw_pkg::tcw_sts_t           sts,
    input  logic [tcw_pkg::FUNC_W-1:0]   in_func,
    input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
    input  logic [tcw_pkg::IN_COL_W-1:0] in_col,
    input  logic [tcw_pkg::IN_ROW_W-1:0] in_row,
    input  logic [tcw_pkg::LINES_W-1:0]  in_scroll_lines,
    input  logic [tcw_pkg::ATTR_W-1:0]   color_attr,
    output logic [tcw_pkg::POS_W-1:0]    cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]   cell_value
);

    import tcw_pkg::*;

    // Latched item.
    logic [FUNC_W-1:0]   item_func_reg;
    logic [CHAR_W-1:0]   item_char_reg;
    logic [IN_COL_W-1:0] item_col_reg;
    logic [IN_ROW_W-1:0] item_row_reg;
    logic [LINES_W-1:0]  item_lines_reg;

    // Cursor kept as row and column.
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;

    // Sweep over the store.
    logic [ADDR_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [ADDR_W-1:0] copy_end_reg, copy_end_next;
    logic [ADDR_W-1:0] shift_reg, shift_next;

    // Result.
    logic [CELL_W-1:0] cell_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CELL_W-1:0] out_cell_reg;

    // Store ports.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    // Derived positions.
    logic [LIN_W-1:0]  lin_base;
    logic [LIN_W-1:0]  lin;
    logic [LIN_W:0]    row_end;
    logic [LIN_W:0]    tab_next;
    logic              tab_wraps;
    logic [COL_W-1:0]  tab_col;
    logic [COL_W-1:0]  clamp_col;
    logic [ROW_W-1:0]  clamp_row;
    logic [ADDR_W-1:0] clamp_pos;
    logic [ADDR_W-1:0] sweep_src;
    logic [NL_W-1:0]   sweep_n;
    logic              sweep_clear;

    // Linear cursor offset and the next tab stop.
    always_comb
    begin
        lin_base  = LIN_W'(cur_row_reg * COLUMNS);
        lin       = lin_base + LIN_W'(cur_col_reg);
        row_end   = {1'b0, lin_base} + (LIN_W+1)'(COLUMNS);
        tab_next  = ({1'b0, lin} + (LIN_W+1)'(TAB_STEP)) & ~(LIN_W+1)'(TAB_MASK);
        tab_wraps = (tab_next >= row_end);
        tab_col   = COL_W'(tab_next - {1'b0, lin_base});
    end

    // Position given with the item, saturated to the screen.
    always_comb
    begin
        clamp_col = (int'(item_col_reg) >= COLUMNS) ? COL_W'(COLUMNS - 1)
                                                    : COL_W'(item_col_reg);
        clamp_row = (int'(item_row_reg) >= ROWS) ? ROW_W'(ROWS - 1)
                                                 : ROW_W'(item_row_reg);
        clamp_pos = ADDR_W'(clamp_row * COLUMNS) + ADDR_W'(clamp_col);
    end

    // Rows moved by a sweep; a full screen or more means a plain clear.
    always_comb
    begin
        unique case (cmd.sweep_kind)
            SW_CLEAR: sweep_n = NL_W'(ROWS);
            SW_ONE:   sweep_n = NL_W'(1);
            SW_ITEM:  sweep_n = NL_W'(item_lines_reg);
            default:  sweep_n = NL_W'(ROWS);
        endcase
        sweep_clear   = (sweep_n >= NL_W'(ROWS));
        copy_end_next = sweep_clear ? '0 : ADDR_W'((ROWS - int'(sweep_n)) * COLUMNS);
        shift_next    = sweep_clear ? '0 : ADDR_W'(sweep_n * COLUMNS);
        sweep_src     = ADDR_W'({1'b0, sweep_idx_reg} + {1'b0, shift_reg});
    end

    // Cursor update and store access for each command.
    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sweep_idx_next = sweep_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = ADDR_W'(lin);
        wr_data        = '0;
        rd_addr        = clamp_pos;

        if (cmd.exec)
        begin
            unique case (item_func_reg)
                FN_PUT:
                begin
                    unique case (item_char_reg)
                        CH_NEWLINE:
                        begin
                            cur_row_next = cur_row_reg + ROW_W'(1);
                            cur_col_next = '0;
                        end
                        CH_TAB:
                        begin
                            if (tab_wraps)
                            begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                                cur_col_next = '0;
                            end
                            else
                            begin
                                cur_col_next = tab_col;
                            end
                        end
                        CH_BACKSPACE:
                        begin
                            if (lin != '0)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = ADDR_W'(lin - LIN_W'(1));
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = cur_col_reg - COL_W'(1);
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg - ROW_W'(1);
                                    cur_col_next = COL_W'(COLUMNS - 1);
                                end
                            end
                        end
                        default:
                        begin
                            wr_en   = 1'b1;
                            wr_data = {color_attr, item_char_reg};
                            if (cur_col_reg == COL_W'(COLUMNS - 1))
                            begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                                cur_col_next = '0;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + COL_W'(1);
                            end
                        end
                    endcase
                end
                FN_SET:
                begin
                    cur_row_next = clamp_row;
                    cur_col_next = clamp_col;
                end
                default:
                begin
                end
            endcase
        end

        // A scroll moves the cursor up with the text, or home when it falls off.
        if (cmd.sweep_start)
        begin
            sweep_idx_next = '0;
            if (sweep_clear || (NL_W'(cur_row_reg) < sweep_n))
            begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            else
            begin
                cur_row_next = ROW_W'(NL_W'(cur_row_reg) - sweep_n);
            end
        end

        if (cmd.sweep_copy_rd)
        begin
            rd_addr = sweep_src;
        end

        if (cmd.sweep_copy_wr)
        begin
            wr_en          = 1'b1;
            wr_addr        = sweep_idx_reg;
            wr_data        = rd_data;
            sweep_idx_next = sweep_idx_reg + ADDR_W'(1);
        end

        if (cmd.sweep_zero)
        begin
            wr_en          = 1'b1;
            wr_addr        = sweep_idx_reg;
            wr_data        = '0;
            sweep_idx_next = sweep_idx_reg + ADDR_W'(1);
        end
    end

    // Cursor and sweep control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            sweep_idx_reg <= '0;
            copy_end_reg  <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sweep_idx_reg <= sweep_idx_next;
            if (cmd.sweep_start)
            begin
                copy_end_reg <= copy_end_next;
                shift_reg    <= shift_next;
            end
        end
    end

    // Item, read data and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_func_reg  <= in_func;
            item_char_reg  <= in_char_code;
            item_col_reg   <= in_col;
            item_row_reg   <= in_row;
            item_lines_reg <= in_scroll_lines;
            cell_reg       <= '0;
        end
        else if (cmd.capture_cell)
        begin
            cell_reg <= rd_data;
        end
        if (cmd.load_out)
        begin
            out_pos_reg  <= POS_W'(lin);
            out_cell_reg <= cell_reg;
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Status back to the controller.
    always_comb
    begin
        sts.func       = item_func_reg;
        sts.lines_zero = (item_lines_reg == '0);
        sts.wrap       = (cur_row_reg == ROW_W'(ROWS));
        sts.sweep_copy = (sweep_idx_reg < copy_end_reg);
        sts.sweep_last = (sweep_idx_reg == ADDR_W'(CELLS - 1));
    end

    assign cursor_pos = out_pos_reg;
    assign cell_value = out_cell_reg;

    // The cursor never leaves the screen by more than the pending wrap row.
    `TCW_ASSERT_SAME(a_cursor_bounds, 1'b1,
        (int'(cur_row_reg) <= ROWS) && (int'(cur_col_reg) < COLUMNS))
    // A copy never reads beyond the store.
    `TCW_ASSERT_SAME(a_copy_src_range, cmd.sweep_copy_rd, int'(sweep_src) < CELLS)
    // Copied cells land only in the region that keeps text.
    `TCW_ASSERT_SAME(a_copy_dst_range, cmd.sweep_copy_wr, sweep_idx_reg < copy_end_reg)

endmodule

// ----- design/tcw_ctrl.sv -----
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t cmd
);

    import tcw_pkg::*;

    state_t state_reg, state_next;
    logic   init_reg, init_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   sweep_end;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign sweep_end = !sts.sweep_copy && sts.sweep_last;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_BOOT:
            begin
                state_next = ST_SWEEP;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (sts.func)
                    FN_PUT:    state_next = ST_WRAP;
                    FN_READ:   state_next = ST_READ;
                    FN_CLEAR:  state_next = ST_SWEEP;
                    FN_SCROLL: state_next = sts.lines_zero ? ST_DONE : ST_SWEEP;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_WRAP:
            begin
                state_next = sts.wrap ? ST_SWEEP : ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                if (sts.sweep_copy)
                begin
                    state_next = ST_SWEEP_WR;
                end
                else if (sts.sweep_last)
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_SWEEP_WR:
            begin
                state_next = ST_SWEEP;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

    // Commands for each state.
    always_comb
    begin
        cmd           = '0;
        cmd.sweep_kind = SW_CLEAR;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_BOOT:
            begin
                cmd.sweep_start = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load_item = s_axis_tvalid;
            end
            ST_EXEC:
            begin
                unique case (sts.func)
                    FN_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                    end
                    FN_SCROLL:
                    begin
                        cmd.sweep_start = !sts.lines_zero;
                        cmd.sweep_kind  = SW_ITEM;
                    end
                    default:
                    begin
                        cmd.exec = 1'b1;
                    end
                endcase
            end
            ST_WRAP:
            begin
                cmd.sweep_start = sts.wrap;
                cmd.sweep_kind  = SW_ONE;
            end
            ST_READ:
            begin
                cmd.capture_cell = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep_copy_rd = sts.sweep_copy;
                cmd.sweep_zero    = !sts.sweep_copy;
            end
            ST_SWEEP_WR:
            begin
                cmd.sweep_copy_wr = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Result beat holding and the boot-time clearing flag.
    always_comb
    begin
        init_next    = init_reg;
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_SWEEP) && sweep_end)
        begin
            init_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BOOT;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    // Only one item is in flight: an accepted beat closes the input.
    `TCW_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A new result never overwrites one that has not been taken.
    `TCW_ASSERT_SAME(a_no_overwrite, cmd.load_out && m_valid_reg, m_axis_tready)
    // Every copy write follows the read of its source cell.
    `TCW_ASSERT_SAME(a_copy_order, state_reg == ST_SWEEP_WR,
        $past(state_reg) == ST_SWEEP)

endmodule

// ----- design/text_console_writer.sv -----
`timescale 1ns / 1ps

// Text-mode console with an 80x25 store of 16-bit cells (attribute in the high byte,
// character in the low byte) and a cursor. Each input beat carries one command in
// s_axis_tuser (0 put character, 1 set cursor, 2 read cell, 3 clear, 4 scroll up) and
// returns exactly one result beat with the linear cursor offset and, for a read, the
// cell. Printable characters take the attribute from the color_attr register on the
// APB port. One command is processed at a time by a controller sequencing a datapath
// around a single-port-write, single-port-read cell memory. Set cursor and unused
// codes pass from acceptance through EXEC to DONE; put character adds WRAP and read
// adds READ before DONE. Clear sweeps the memory one cell per cycle. Scrolling N rows
// copies each kept cell with a read state and a write state, then zeroes the vacated
// rows; a character that runs off the last row triggers a one-row scroll. After reset
// a clearing pass runs before the first input beat is accepted; register writes are
// accepted throughout. A finished result waits in an output register while the next
// command is accepted.
module text_console_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // char_code[7:0], col[14:8], row[19:15], scroll_lines[24:20], zero above.
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[2:0].
    input  logic [tcw_pkg::FUNC_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cursor_pos[10:0], cell_value[26:11], zero above.
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_AW-1:0]      paddr,
    input  logic [tcw_pkg::APB_DW-1:0]      pwdata,
    output logic [tcw_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    import tcw_pkg::*;

    logic [ATTR_W-1:0] color_attr_reg, color_attr_next;
    logic              reg_sel;
    logic              reg_write;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;

    // Attribute register; the word index is the address above the byte offset.
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_AW-1:2] == REG_COLOR_ATTR);
    assign reg_write = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        color_attr_next = color_attr_reg;
        if (reg_write)
        begin
            color_attr_next = pwdata[ATTR_W-1:0];
        end
        prdata = reg_sel ? APB_DW'(color_attr_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_attr_reg <= COLOR_ATTR_RESET;
        end
        else
        begin
            color_attr_reg <= color_attr_next;
        end
    end

    tcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_axis_tuser),
        .in_char_code    (s_axis_tdata[7:0]),
        .in_col          (s_axis_tdata[14:8]),
        .in_row          (s_axis_tdata[19:15]),
        .in_scroll_lines (s_axis_tdata[24:20]),
        .color_attr      (color_attr_reg),
        .cursor_pos      (cursor_pos),
        .cell_value      (cell_value)
    );

    // Result beat packing.
    assign m_axis_tdata = {(M_TDATA_W - POS_W - CELL_W)'(0), cell_value, cursor_pos};

endmodule
